### hw/rtl/rrc_pkg.sv
// Shared types, widths and constants for the rotated rectangle corner block.
// Holds the CORDIC angle table and the corner codes used by the corner generator and the testbench.
// No dependencies.
package rrc_pkg;

	// Field widths of the stream payloads.
	localparam int COORD_BITS   = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int ROT_BITS     = 16;
	localparam int WIDTH_BITS   = 15;
	localparam int HALF_BITS    = WIDTH_BITS - 1;
	localparam int IN_W         = 2 * COORD_BITS + 2 * WIDTH_BITS + ROT_BITS;
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;

	// CORDIC word format: binary angle with a full turn at 2^32, vectors in Q2.30.
	localparam int CW           = 32;
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_W       = 5;
	localparam logic signed [CW-1:0] CORDIC_GAIN    = 32'sd652032874;
	localparam logic [CW-1:0]        QUARTER_OFFSET = 32'h2000_0000;

	// Sine and cosine in Q1.15, products and corner sums.
	localparam int Q15_W  = 16;
	localparam int FRAC   = 15;
	localparam int PROD_W = HALF_BITS + 1 + Q15_W;
	localparam int SUM_W  = ((PROD_W > COORD_BITS + FRAC) ? PROD_W : COORD_BITS + FRAC) + 2;

	// Corner order on the output stream.
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	// Rectangle geometry carried alongside the CORDIC vector.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [HALF_BITS-1:0]         hw;
		logic [HALF_BITS-1:0]         hh;
		logic [1:0]                   quad;
	} rect_t;

	// One CORDIC stage worth of state.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		rect_t                rect;
	} cordic_t;

	// Finished sine and cosine with the rectangle.
	typedef struct packed {
		logic signed [Q15_W-1:0] c_val;
		logic signed [Q15_W-1:0] s_val;
		rect_t                   rect;
	} trig_t;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic signed [CW-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic signed [CW-1:0] a;
		case (i)
			5'd0:    a = 32'sh2000_0000;
			5'd1:    a = 32'sh12E4_051E;
			5'd2:    a = 32'sh09FB_385B;
			5'd3:    a = 32'sh0511_11D4;
			5'd4:    a = 32'sh028B_0D43;
			5'd5:    a = 32'sh0145_D7E1;
			5'd6:    a = 32'sh00A2_F61E;
			5'd7:    a = 32'sh0051_7C55;
			5'd8:    a = 32'sh0028_BE53;
			5'd9:    a = 32'sh0014_5F2F;
			5'd10:   a = 32'sh000A_2F98;
			5'd11:   a = 32'sh0005_17CC;
			5'd12:   a = 32'sh0002_8BE6;
			5'd13:   a = 32'sh0001_45F3;
			5'd14:   a = 32'sh0000_A2FA;
			5'd15:   a = 32'sh0000_517D;
			5'd16:   a = 32'sh0000_28BE;
			5'd17:   a = 32'sh0000_145F;
			5'd18:   a = 32'sh0000_0A30;
			5'd19:   a = 32'sh0000_0518;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### hw/rtl/rrc_cordic_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation and its output register.
// Depends on rrc_pkg for the stage type and the arctangent table.
module rrc_cordic_cell import rrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  logic              in_valid,
	input  cordic_t           in_data,
	output logic              out_valid,
	output cordic_t           out_data
);

	logic signed [CW-1:0] x_in;
	logic signed [CW-1:0] y_in;
	logic signed [CW-1:0] z_in;
	logic signed [CW-1:0] x_sh;
	logic signed [CW-1:0] y_sh;
	logic signed [CW-1:0] ang;
	cordic_t              nxt;

	// Rotate toward zero residual angle; the shifts round toward minus infinity.
	always_comb begin
		x_in = in_data.x;
		y_in = in_data.y;
		z_in = in_data.z;
		x_sh = y_in >>> step;
		y_sh = x_in >>> step;
		ang  = atan_step(step);
		nxt.rect = in_data.rect;
		if (!z_in[CW-1]) begin
			nxt.x = x_in - x_sh;
			nxt.y = y_in + y_sh;
			nxt.z = z_in - ang;
		end else begin
			nxt.x = x_in + x_sh;
			nxt.y = y_in - y_sh;
			nxt.z = z_in + ang;
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

### hw/rtl/rrc_corner_gen.sv
// Corner generator: forms the four rotated corners of one rectangle, one per cycle unless m_tready stalls it.
// Depends on rrc_pkg for the trig type, widths and corner codes.
module rrc_corner_gen import rrc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  trig_t                  in_data,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // corner_x, corner_y
	output logic [1:0]             m_tuser,  // corner_index
	output logic                   m_tlast   // last_corner
);

	localparam int RES_W = SUM_W - FRAC;

	logic signed [PROD_W-1:0]     hwc_q, hhs_q, hws_q, hhc_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic                         pv_q;
	logic [1:0]                   k_q;
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [1:0]                   idx_q;
	logic                         last_q;
	logic                         valid_q;

	logic                         emit;
	logic                         load;
	logic                         neg_x, neg_y, is_last;
	logic signed [PROD_W-1:0]     hw_s, hh_s;
	logic signed [SUM_W-1:0]      a_x, b_x, a_y, b_y, xt, yt;
	logic signed [RES_W-1:0]      xr, yr;
	logic signed [COORD_BITS-1:0] xs, ys;

	// Clamp a truncated sum to the signed coordinate range.
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [RES_W-1:0] v
	);
		logic hi_ones;
		logic hi_any;
		logic signed [COORD_BITS-1:0] r;
		hi_ones = &v[RES_W-1:COORD_BITS-1];
		hi_any  = |v[RES_W-1:COORD_BITS-1];
		if (v[RES_W-1] && !hi_ones) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else if (!v[RES_W-1] && hi_any) begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	// Division by 2^15 that truncates toward zero.
	function automatic logic signed [RES_W-1:0] trunc_frac(
		input logic signed [SUM_W-1:0] t
	);
		logic signed [SUM_W-1:0] b;
		b = t + (t[SUM_W-1] ? SUM_W'({FRAC{1'b1}}) : SUM_W'(0));
		return RES_W'(b >>> FRAC);
	endfunction

	// Handshake between the product register and the output register.
	assign emit     = pv_q && (!valid_q || m_tready);
	assign is_last  = (k_q == CORNER_BL);
	assign in_ready = !pv_q || (emit && is_last);
	assign load     = in_valid && in_ready;

	// Half sizes as signed multiplier operands.
	assign hw_s = PROD_W'(signed'({1'b0, in_data.rect.hw}));
	assign hh_s = PROD_W'(signed'({1'b0, in_data.rect.hh}));

	// Products of the half sizes with sine and cosine, once per rectangle.
	always_ff @(posedge clk) begin
		if (load) begin
			hwc_q <= hw_s * PROD_W'(in_data.c_val);
			hhs_q <= hh_s * PROD_W'(in_data.s_val);
			hws_q <= hw_s * PROD_W'(in_data.s_val);
			hhc_q <= hh_s * PROD_W'(in_data.c_val);
			cx_q  <= in_data.rect.cx;
			cy_q  <= in_data.rect.cy;
		end
	end

	// Product register occupancy and the corner counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			k_q  <= CORNER_TL;
		end else begin
			if (load) begin
				pv_q <= 1'b1;
			end else if (emit && is_last) begin
				pv_q <= 1'b0;
			end
			if (emit) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// Corner signs: left corners negate the half width, top corners the half height.
	always_comb begin
		neg_x = (k_q == CORNER_TL) || (k_q == CORNER_BL);
		neg_y = (k_q == CORNER_TL) || (k_q == CORNER_TR);
		a_x   = neg_x ? -SUM_W'(hwc_q) : SUM_W'(hwc_q);
		b_x   = neg_y ? -SUM_W'(hhs_q) : SUM_W'(hhs_q);
		a_y   = neg_x ? -SUM_W'(hws_q) : SUM_W'(hws_q);
		b_y   = neg_y ? -SUM_W'(hhc_q) : SUM_W'(hhc_q);
		xt    = a_x - b_x + (SUM_W'(cx_q) <<< FRAC);
		yt    = a_y + b_y + (SUM_W'(cy_q) <<< FRAC);
		xr    = trunc_frac(xt);
		yr    = trunc_frac(yt);
		xs    = sat_coord(xr);
		ys    = sat_coord(yr);
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			x_q    <= xs;
			y_q    <= ys;
			idx_q  <= k_q;
			last_q <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_TDATA_W'({y_q, x_q});
	assign m_tuser  = idx_q;
	assign m_tlast  = last_q;

endmodule

### hw/rtl/rotated_rectangle_corners.sv
// Rotated rectangle corners: top level with angle split, CORDIC cell chain, finishing stage and corner generator.
// Depends on rrc_pkg, rrc_cordic_cell and rrc_corner_gen.
//
// Usage: one transaction on the s_ channel carries a rectangle (center, width, height,
// binary rotation angle). The m_ channel returns four transactions per rectangle, the
// corners top-left, top-right, bottom-right, bottom-left, with corner_index on m_tuser
// and m_tlast set on the fourth corner. Coordinates are truncated toward zero and
// saturated to 16-bit signed range.
// Path: an accepted rectangle passes the entry register, the CORDIC cells and the finishing
// register into the product register; its corners then leave through the output register.
// Throughput: the single output port emits one corner per cycle while m_tready is high, and a
// rectangle has four corners. The 20-cell CORDIC chain accepts a new rectangle every cycle
// when not stalled; up to 23 rectangles are in flight and s_tready is high while the chain has room.
// Stall: when m_tready is low the output register holds its corner; the corner generator
// and then the chain stop as a whole, and s_tready falls once the chain end is occupied.
// Reset: arst_n clears all valid bits at once; the block accepts input right after reset.
module rotated_rectangle_corners import rrc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // center_x, center_y, rect_width, rect_height,
	                                         // rotation
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // corner_x, corner_y
	output logic [1:0]             m_tuser,  // corner_index
	output logic                   m_tlast   // last_corner
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;
	localparam int RND_W = CW + 1 - FRAC;

	localparam int OFS_CY  = COORD_BITS;
	localparam int OFS_W   = 2 * COORD_BITS;
	localparam int OFS_H   = OFS_W + WIDTH_BITS;
	localparam int OFS_ROT = OFS_H + WIDTH_BITS;

	logic                     en;
	logic                     cg_ready;
	logic                     stage_valid [0:CORDIC_STEPS];
	cordic_t                  stage_data  [0:CORDIC_STEPS];

	logic signed [ROT_BITS-1:0] rot_in;
	logic [WIDTH_BITS-1:0]      w_in, h_in;
	logic [ANGLE_BITS-1:0]      ang;
	logic [CW-1:0]              a32;
	logic [CW-1:0]              a_ofs;
	logic [1:0]                 quad;
	cordic_t                    entry;

	logic signed [CW-1:0]       xe, ye, xc, yc;
	trig_t                      fin_d;
	trig_t                      fin_q;
	logic                       fin_valid_q;

	// The whole chain advances unless a finished rectangle waits at its end.
	assign en       = !fin_valid_q || cg_ready;
	assign s_tready = en;

	// Split the angle into a quadrant and a residual within one eighth of a turn.
	always_comb begin
		rot_in = s_tdata[OFS_ROT +: ROT_BITS];
		w_in   = s_tdata[OFS_W +: WIDTH_BITS];
		h_in   = s_tdata[OFS_H +: WIDTH_BITS];
		ang    = ANGLE_BITS'(rot_in);
		a32    = CW'(ang) << (CW - ANGLE_BITS);
		a_ofs  = a32 + QUARTER_OFFSET;
		quad   = a_ofs[CW-1:CW-2];
		entry.x         = CORDIC_GAIN;
		entry.y         = '0;
		entry.z         = a32 - {quad, {(CW-2){1'b0}}};
		entry.rect.cx   = s_tdata[COORD_BITS-1:0];
		entry.rect.cy   = s_tdata[OFS_CY +: COORD_BITS];
		entry.rect.hw   = w_in[WIDTH_BITS-1:1];
		entry.rect.hh   = h_in[WIDTH_BITS-1:1];
		entry.rect.quad = quad;
	end

	// Entry register of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid[0] <= 1'b0;
		end else if (en) begin
			stage_valid[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_data[0] <= entry;
		end
	end

	// Chain of CORDIC cells, one micro-rotation each.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		rrc_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (STEP_W'(i)),
			.in_valid  (stage_valid[i]),
			.in_data   (stage_data[i]),
			.out_valid (stage_valid[i+1]),
			.out_data  (stage_data[i+1])
		);
	end

	// Undo the quadrant split and round to Q1.15 with saturation.
	function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CW-1:0] v);
		logic signed [CW:0]      t;
		logic signed [RND_W-1:0] r;
		logic signed [Q15_W-1:0] o;
		t = (CW+1)'(v) + (CW+1)'(1 << (FRAC - 1));
		r = RND_W'(t >>> FRAC);
		if (r[RND_W-1] && !(&r[RND_W-1:Q15_W-1])) begin
			o = {1'b1, {(Q15_W-1){1'b0}}};
		end else if (!r[RND_W-1] && (|r[RND_W-1:Q15_W-1])) begin
			o = {1'b0, {(Q15_W-1){1'b1}}};
		end else begin
			o = r[Q15_W-1:0];
		end
		return o;
	endfunction

	always_comb begin
		xe = stage_data[CORDIC_STEPS].x;
		ye = stage_data[CORDIC_STEPS].y;
		case (stage_data[CORDIC_STEPS].rect.quad)
			QUAD_1: begin
				xc = -ye;
				yc = xe;
			end
			QUAD_2: begin
				xc = -xe;
				yc = -ye;
			end
			QUAD_3: begin
				xc = ye;
				yc = -xe;
			end
			QUAD_0: begin
				xc = xe;
				yc = ye;
			end
			default: begin
				xc = xe;
				yc = ye;
			end
		endcase
		fin_d.c_val = to_q15(xc);
		fin_d.s_val = to_q15(yc);
		fin_d.rect  = stage_data[CORDIC_STEPS].rect;
	end

	// Finishing register at the end of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= 1'b0;
		end else if (en) begin
			fin_valid_q <= stage_valid[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_q <= fin_d;
		end
	end

	// Corner products, sequencing and output register.
	rrc_corner_gen u_corner_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fin_valid_q),
		.in_ready (cg_ready),
		.in_data  (fin_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### tb/rotated_rectangle_corners_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotated_rectangle_corners: streams rectangles in and checks every
// corner against a bit-exact CORDIC and corner predictor kept in the testbench.
// Depends on rrc_pkg and the rotated_rectangle_corners RTL.
module rotated_rectangle_corners_test;
	import rrc_pkg::*;

	localparam int     LIMIT_CYCLES = 300000;
	localparam int     DRAIN_CYCLES = 60;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     RANDOM_RECTS = 410;
	localparam int     MAX_REPORTS  = 10;
	localparam longint ONE_Q15      = 32768;
	localparam longint GAIN_Q30     = 652032874;

	// Arctangent of 2^-i as a binary angle with a full turn at 2^32, entry i at bits [32*i +: 32].
	localparam logic [20*32-1:0] ARCTAN_TURNS = {
		32'h0000_0518, 32'h0000_0A30, 32'h0000_145F, 32'h0000_28BE, 32'h0000_517D,
		32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6, 32'h0005_17CC, 32'h000A_2F98,
		32'h0014_5F2F, 32'h0028_BE53, 32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1,
		32'h028B_0D43, 32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx, cy;
		logic [WIDTH_BITS-1:0]        w, h;
		logic [ROT_BITS-1:0]          rot;
	} rect_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x, y;
		logic [1:0]                   idx;
		logic                         last;
	} corner_t;

	// A directed row; fixed rows carry the one point that all four corners collapse to.
	typedef struct packed {
		rect_item_t                   r;
		logic                         fixed;
		logic signed [COORD_BITS-1:0] ex, ey;
	} rect_row_t;

	typedef enum {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // center_x, center_y, rect_width, rect_height, rotation
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // corner_x, corner_y
	logic [1:0]             m_tuser;   // corner_index
	logic                   m_tlast;   // last_corner

	corner_t   pending_corners[$];
	rect_row_t directed_rows[$];
	int        mismatches  = 0;
	int        cycle_count = 0;
	bit        hold_req    = 1'b0;

	rotated_rectangle_corners u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Round a Q30 value to Q15 with round-half-up and clamp to the 16-bit range.
	function automatic longint q30_to_q15(input longint v);
		longint t;
		t = (v + 16384) >>> 15;
		if (t > 32767)
			t = 32767;
		else if (t < -32768)
			t = -32768;
		return t;
	endfunction

	// Drop the Q15 fraction toward zero and clamp to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] q15_to_coord(input longint t);
		longint v;
		longint hi;
		hi = (longint'(1) << (COORD_BITS - 1)) - 1;
		v  = (t < 0) ? -((-t) >>> 15) : (t >>> 15);
		if (v > hi)
			v = hi;
		else if (v < -hi - 1)
			v = -hi - 1;
		return v[COORD_BITS-1:0];
	endfunction

	// Cosine and sine of a binary angle: quadrant split, 20 CORDIC rotations, quarter turns.
	task automatic rotation_trig(input logic [ROT_BITS-1:0] rot, output longint cos_q15,
			output longint sin_q15);
		logic [31:0] turn32;
		logic [31:0] shifted;
		logic [31:0] residual;
		logic [1:0]  quad;
		longint      x, y, z, xs, ys, xq, yq;
		turn32   = {rot, {(32 - ROT_BITS){1'b0}}};
		shifted  = turn32 + 32'h2000_0000;
		quad     = shifted[31:30];
		residual = turn32 - {quad, 30'b0};
		z = longint'($signed(residual));
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = y >>> i;
			ys = x >>> i;
			if (z >= 0) begin
				x = x - xs;
				y = y + ys;
				z = z - longint'(ARCTAN_TURNS[32*i +: 32]);
			end else begin
				x = x + xs;
				y = y - ys;
				z = z + longint'(ARCTAN_TURNS[32*i +: 32]);
			end
		end
		case (quad)
			2'd1: begin xq = -y; yq = x;  end
			2'd2: begin xq = -x; yq = -y; end
			2'd3: begin xq = y;  yq = -x; end
			default: begin xq = x; yq = y; end
		endcase
		cos_q15 = q30_to_q15(xq);
		sin_q15 = q30_to_q15(yq);
	endtask

	// Work out the four rotated corners of one rectangle and queue them in output order.
	task automatic queue_rect_corners(input rect_item_t r);
		longint     c, s, hw, hh, dx, dy, cx, cy;
		logic [1:0] corner;
		corner_t    exp_c;
		rotation_trig(r.rot, c, s);
		cx = longint'(r.cx);
		cy = longint'(r.cy);
		hw = longint'(r.w >> 1);
		hh = longint'(r.h >> 1);
		for (int k = 0; k < 4; k++) begin
			corner = 2'(k);
			dx = (corner == CORNER_TR || corner == CORNER_BR) ? hw : -hw;
			dy = (corner == CORNER_BR || corner == CORNER_BL) ? hh : -hh;
			exp_c.x    = q15_to_coord(dx * c - dy * s + cx * ONE_Q15);
			exp_c.y    = q15_to_coord(dx * s + dy * c + cy * ONE_Q15);
			exp_c.idx  = corner;
			exp_c.last = (corner == CORNER_BL);
			pending_corners.push_back(exp_c);
		end
	endtask

	function automatic void add_row(input int cx, input int cy, input int w, input int h,
			input int rot, input bit fixed, input int ex, input int ey);
		rect_row_t row;
		row.r.cx  = cx[COORD_BITS-1:0];
		row.r.cy  = cy[COORD_BITS-1:0];
		row.r.w   = w[WIDTH_BITS-1:0];
		row.r.h   = h[WIDTH_BITS-1:0];
		row.r.rot = rot[ROT_BITS-1:0];
		row.fixed = fixed;
		row.ex    = ex[COORD_BITS-1:0];
		row.ey    = ey[COORD_BITS-1:0];
		directed_rows.push_back(row);
	endfunction

	// Random rectangle: plain noise, small shapes, angles near quadrant edges, or saturating ones.
	function automatic rect_item_t random_rect();
		rect_item_t r;
		int         kind;
		kind  = $urandom_range(0, 99);
		r.cx  = COORD_BITS'($urandom);
		r.cy  = COORD_BITS'($urandom);
		r.w   = WIDTH_BITS'($urandom);
		r.h   = WIDTH_BITS'($urandom);
		r.rot = ROT_BITS'($urandom);
		if (kind < 35) begin
			r.cx = COORD_BITS'($urandom_range(0, 4000) - 2000);
			r.cy = COORD_BITS'($urandom_range(0, 4000) - 2000);
			r.w  = WIDTH_BITS'($urandom_range(0, 400));
			r.h  = WIDTH_BITS'($urandom_range(0, 400));
		end else if (kind < 55) begin
			r.rot = ROT_BITS'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
		end else if (kind < 70) begin
			r.cx = ($urandom_range(0, 1) == 1) ? COORD_BITS'(32767) : COORD_BITS'(-32768);
			r.cy = ($urandom_range(0, 1) == 1) ? COORD_BITS'(32767) : COORD_BITS'(-32768);
			r.w  = WIDTH_BITS'($urandom_range(30000, 32767));
			r.h  = WIDTH_BITS'($urandom_range(30000, 32767));
		end
		return r;
	endfunction

	// Offer one rectangle and hold it until the block takes it.
	task automatic send_rect(input rect_row_t row);
		corner_t fixed_c;
		s_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, row.r.rot, row.r.h, row.r.w, row.r.cy,
			row.r.cx};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (row.fixed) begin
			for (int k = 0; k < 4; k++) begin
				fixed_c.x    = row.ex;
				fixed_c.y    = row.ey;
				fixed_c.idx  = 2'(k);
				fixed_c.last = (2'(k) == CORNER_BL);
				pending_corners.push_back(fixed_c);
			end
		end else begin
			queue_rect_corners(row.r);
		end
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (pending_corners.size() != 0) begin
			s_tvalid <= 1'b0;
			while (pending_corners.size() != 0)
				@(posedge clk);
		end
	endtask

	// Stimulus: directed table, then bursts of random rectangles.
	initial begin
		rect_row_t row;
		int        burst_left;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;

		// Zero-size rectangles collapse to their center at any angle.
		add_row(0, 0, 0, 0, 0, 1, 0, 0);
		add_row(32767, -32768, 1, 0, -32768, 1, 32767, -32768);
		add_row(-32768, 32767, 0, 1, 16384, 1, -32768, 32767);
		add_row(1234, -4321, 1, 1, 8191, 1, 1234, -4321);
		// Each quadrant, the quadrant edges and the smallest angle steps.
		add_row(0, 0, 100, 50, 0, 0, 0, 0);
		add_row(0, 0, 100, 50, 16384, 0, 0, 0);
		add_row(0, 0, 100, 50, -32768, 0, 0, 0);
		add_row(0, 0, 100, 50, -16384, 0, 0, 0);
		add_row(0, 0, 101, 51, 8192, 0, 0, 0);
		add_row(0, 0, 3, 3, 8191, 0, 0, 0);
		add_row(10, 20, 2000, 1000, 24576, 0, 0, 0);
		add_row(-5, 7, 2000, 1000, -8192, 0, 0, 0);
		add_row(0, 0, 1000, 1000, 1, 0, 0, 0);
		add_row(0, 0, 1000, 1000, -1, 0, 0, 0);
		add_row(-1, -1, 2, 2, 4096, 0, 0, 0);
		add_row(100, -100, 0, 32767, 16383, 0, 0, 0);
		// Largest sizes, mostly at the edges of the screen, so that corners saturate both ways.
		add_row(0, 0, 32767, 32767, 0, 0, 0, 0);
		add_row(32767, 32767, 32767, 32767, 0, 0, 0, 0);
		add_row(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
		add_row(32767, -32768, 32767, 32767, 8192, 0, 0, 0);
		add_row(-32768, 32767, 32767, 0, -32768, 0, 0, 0);
		add_row(0, 0, 32767, 32767, 32767, 0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_rect(directed_rows[i]);
			idle_cycles($urandom_range(0, 2));
		end
		wait_drained();

		burst_left = 0;
		row.fixed  = 1'b0;
		row.ex     = '0;
		row.ey     = '0;
		for (int n = 0; n < RANDOM_RECTS; n++) begin
			if (burst_left == 0) begin
				idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 12);
			end
			// Long output hold-off while input keeps coming, later a full drain.
			if (n == 150)
				hold_req = 1'b1;
			if (n == 300)
				wait_drained();
			row.r = random_rect();
			send_rect(row);
			burst_left--;
		end

		wait_drained();
		s_tvalid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Output back-pressure: a random mode per stretch, plus one long hold-off on request.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		m_tready  = 1'b0;
		mode      = RX_STREAM;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					RX_STREAM:    m_tready <= 1'b1;
					RX_MOSTLY:    m_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE:    m_tready <= ($urandom_range(0, 3) == 0);
					RX_ALTERNATE: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Compare every accepted corner transaction with the oldest pending corner.
	always @(posedge clk) begin
		corner_t got;
		corner_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x    = m_tdata[COORD_BITS-1:0];
			got.y    = m_tdata[2*COORD_BITS-1:COORD_BITS];
			got.idx  = m_tuser;
			got.last = m_tlast;
			if (pending_corners.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected corner: x=%0d y=%0d idx=%0d last=%0b",
						got.x, got.y, got.idx, got.last);
			end else begin
				want = pending_corners.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.idx !== want.idx
						|| got.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("corner mismatch: expected x=%0d y=%0d idx=%0d last=%0b, %s",
							want.x, want.y, want.idx, want.last,
							$sformatf("got x=%0d y=%0d idx=%0d last=%0b",
								got.x, got.y, got.idx, got.last));
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
